/* sv/linear_index_to_coordinates_unit_assert.svh */
// assertion macros for the index to coordinates unit
`ifndef LINEAR_INDEX_TO_COORDINATES_UNIT_ASSERT_SVH
`define LINEAR_INDEX_TO_COORDINATES_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define LIC_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define LIC_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* sv/lic_pkg.sv */
// shared constants and types for the index to coordinates unit
`default_nettype none
package lic_pkg;
   localparam int RANK_LIMIT = 4;
   localparam int NUM_DIMS = 4;
   localparam int IDX_W = 32;
   localparam int EXT_W = 16;
   localparam int DIM_W = $clog2(NUM_DIMS);
   // quotient bits resolved per cell
   localparam int BITS_PER_CELL = 4;
   localparam int CELLS_PER_DIM = IDX_W / BITS_PER_CELL;
   localparam int NUM_CELLS = NUM_DIMS * CELLS_PER_DIM;

   typedef logic [EXT_W-1:0] ext_type;

   // data moving from one cell to the next
   typedef struct packed {
      logic                                valid;
      logic [IDX_W-1:0]                    rem;    // partial remainder / index
      logic [IDX_W-1:0]                    quo;    // quotient bits so far
      logic [NUM_DIMS-1:0][EXT_W-1:0]      coord;
      logic [NUM_DIMS-1:0][EXT_W-1:0]      ext;    // extents carried with the request
   } lane_type;
endpackage
`default_nettype wire

/* sv/linear_index_to_coordinates_unit.sv */
// Mixed-radix index decomposition: a row of 32 division cells, eight per
// dimension, each resolving four quotient bits against the dimension's extent.
// A request is taken every cycle unless a stalled result holds the chain; each
// result passes through the 32 cell registers in order. Extents are sampled with the
// request, and a stalled result holds the whole chain in place.
`default_nettype none
`include "linear_index_to_coordinates_unit_assert.svh"
module linear_index_to_coordinates_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_linear_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_coord_0,
   output logic [15:0]      rsp_coord_1,
   output logic [15:0]      rsp_coord_2,
   output logic [15:0]      rsp_coord_3,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   lic_pkg::ext_type  ext_ff [lic_pkg::NUM_DIMS];
   lic_pkg::lane_type lanes [lic_pkg::NUM_CELLS+1];
   lic_pkg::lane_type head;
   logic advance;
   logic [15:0] out_ext_0;

   // extent registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < lic_pkg::NUM_DIMS; d++) ext_ff[d] <= 16'd1;
      end else if (csr_write) begin
         ext_ff[csr_index] <= csr_data;
      end
   end

   // chain moves unless the last stage holds an untaken result
   assign advance   = !(lanes[lic_pkg::NUM_CELLS].valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      head       = '0;
      head.valid = req_valid;
      head.rem   = req_linear_index;
      for (int d = 0; d < lic_pkg::NUM_DIMS; d++) head.ext[d] = ext_ff[d];
   end
   assign lanes[0] = head;

   // cell row
   for (genvar c = 0; c < lic_pkg::NUM_CELLS; c++) begin : g_cell
      lic_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .dim    (lic_pkg::DIM_W'(c / lic_pkg::CELLS_PER_DIM)),
         .first  ((c % lic_pkg::CELLS_PER_DIM) == 0),
         .last   ((c % lic_pkg::CELLS_PER_DIM) == lic_pkg::CELLS_PER_DIM - 1),
         .lane_i (lanes[c]),
         .lane_o (lanes[c+1])
      );
   end

   assign rsp_valid   = lanes[lic_pkg::NUM_CELLS].valid;
   assign rsp_coord_0 = lanes[lic_pkg::NUM_CELLS].coord[0];
   assign rsp_coord_1 = lanes[lic_pkg::NUM_CELLS].coord[1];
   assign rsp_coord_2 = lanes[lic_pkg::NUM_CELLS].coord[2];
   assign rsp_coord_3 = lanes[lic_pkg::NUM_CELLS].coord[3];
   assign out_ext_0   = lanes[lic_pkg::NUM_CELLS].ext[0];

   // a stalled result holds coordinate 0; coordinate 0 stays below a nonzero extent
   `LIC_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_coord_0))
   `LIC_ASSERT_IMP(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
   `LIC_ASSERT_IMP(a_c0, clock, reset, rsp_valid && out_ext_0 != 16'd0, rsp_coord_0 < out_ext_0)
endmodule
`default_nettype wire

/* sv/lic_cell.sv */
// one cell: four restoring division steps, with dimension hand-off at the last cell
`default_nettype none
module lic_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [lic_pkg::DIM_W-1:0] dim,
   input  wire logic                first,
   input  wire logic                last,
   input  wire lic_pkg::lane_type   lane_i,
   output lic_pkg::lane_type        lane_o
);
   lic_pkg::lane_type lane_ff, lane_in;
   logic [lic_pkg::EXT_W-1:0] ext_raw;
   logic [lic_pkg::EXT_W:0]   ext_eff;
   logic                      active;
   logic [lic_pkg::IDX_W-1:0] num;
   logic [lic_pkg::IDX_W-1:0] quo;
   logic [lic_pkg::EXT_W:0]   part;
   logic [lic_pkg::EXT_W+1:0] trial;

   // a zero extent or a dimension past the rank acts as extent one
   assign ext_raw = lane_i.ext[dim];
   assign active  = (32'(dim) < lic_pkg::RANK_LIMIT) && (ext_raw != '0);
   assign ext_eff = active ? {1'b0, ext_raw} : 17'd1;

   always_comb begin
      lane_in = lane_i;
      // at the first cell of a dimension the remainder field holds the dividend
      if (first) begin
         num  = lane_i.rem;
         part = '0;
      end else begin
         num  = lane_i.quo;
         part = lane_i.rem[lic_pkg::EXT_W:0];
      end
      quo = num;
      for (int b = 0; b < lic_pkg::BITS_PER_CELL; b++) begin
         trial = {part, quo[lic_pkg::IDX_W-1]};
         quo   = {quo[lic_pkg::IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, ext_eff}) begin
            part   = (lic_pkg::EXT_W+1)'(trial - {1'b0, ext_eff});
            quo[0] = 1'b1;
         end else begin
            part = trial[lic_pkg::EXT_W:0];
         end
      end
      if (last) begin
         // remainder is the coordinate; quotient feeds the next dimension
         lane_in.coord[dim] = active ? part[lic_pkg::EXT_W-1:0] : '0;
         lane_in.rem        = quo;
         lane_in.quo        = '0;
      end else begin
         lane_in.rem = {{(lic_pkg::IDX_W-lic_pkg::EXT_W-1){1'b0}}, part};
         lane_in.quo = quo;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;
endmodule
`default_nettype wire

/* tb/lic_checker.sv */
// checker for the index to coordinates unit: predicts coordinates and compares results
module lic_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [31:0] req_linear_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [15:0] rsp_coord_0,
   input  wire logic [15:0] rsp_coord_1,
   input  wire logic [15:0] rsp_coord_2,
   input  wire logic [15:0] rsp_coord_3,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending_count
);
   typedef logic [lic_pkg::NUM_DIMS-1:0][lic_pkg::EXT_W-1:0] coord_set_type;

   lic_pkg::ext_type shape [lic_pkg::NUM_DIMS];
   coord_set_type    coord_queue [$];

   // mixed-radix split of one index against the current shape
   function automatic coord_set_type split_index(logic [lic_pkg::IDX_W-1:0] idx);
      coord_set_type             c;
      logic [lic_pkg::IDX_W-1:0] rest;
      rest = idx;
      for (int d = 0; d < lic_pkg::NUM_DIMS; d++) begin
         c[d] = '0;
         if (d < lic_pkg::RANK_LIMIT && shape[d] != 0) begin
            c[d] = lic_pkg::EXT_W'(rest % shape[d]);
            rest = rest / shape[d];
         end
      end
      return c;
   endfunction

   // track shape, queue predictions, compare results
   always @(posedge clock) begin
      coord_set_type got, want;
      if (reset) begin
         for (int d = 0; d < lic_pkg::NUM_DIMS; d++) shape[d] = 1;
         coord_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_coord_3, rsp_coord_2, rsp_coord_1, rsp_coord_0};
            if (coord_queue.size() == 0) begin
               $display("%0t unexpected response expected none actual %h", $time, got);
               fail_count++;
            end else begin
               want = coord_queue.pop_front();
               for (int d = 0; d < lic_pkg::NUM_DIMS; d++)
                  if (want[d] !== got[d]) begin
                     $display("%0t coord_%0d expected %0d actual %0d",
                              $time, d, want[d], got[d]);
                     fail_count++;
                  end
            end
         end
         if (req_valid && !req_stall)
            coord_queue.insert(coord_queue.size(), split_index(req_linear_index));
         if (csr_write) shape[csr_index] = csr_data;
      end
      pending_count = coord_queue.size();
   end
endmodule

/* tb/tb.sv */
// top of the testbench for the index to coordinates unit: stimulus and verdict
module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_linear_index = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [15:0] rsp_coord_0, rsp_coord_1, rsp_coord_2, rsp_coord_3;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_data = 0;
   int          fail_count, pending_count;
   bit          hold_rsp = 0;
   bit          stim_done = 0;
   int          idle_cycles = 0;

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   linear_index_to_coordinates_unit DUT (.*);
   lic_checker u_checker (.*);

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || hold_rsp)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stall per response, long hold when asked
   initial begin
      int w;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (80) @(negedge clock);
            hold_rsp = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (w > 0) begin
            rsp_stall <= 1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(logic [31:0] idx, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 6) : 0;
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(negedge clock);
      end
      req_valid <= 1;
      req_linear_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // wait until all responses are back and the pipe is empty
   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_shape(logic [15:0] e0, e1, e2, e3);
      logic [15:0] e [4];
      e = '{e0, e1, e2, e3};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1;
         csr_index <= i[1:0];
         csr_data <= e[i];
         @(negedge clock);
      end
      csr_write <= 0;
   endtask

   function automatic logic [15:0] rand_extent();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return 16'hffff;
         2: return 16'd0;
         3: return 16'($urandom_range(2, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_index();
      case ($urandom_range(0, 3))
         0: return 32'hffffffff;
         1: return 32'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: reset shape, extremes, zero extents, wraparound
      send_request(32'h0, 0);
      send_request(32'hffffffff, 0);
      set_shape(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_request(32'hffffffff, 0);
      send_request(32'h0, 0);
      send_request(32'h5555aaaa, 0);
      set_shape(16'd0, 16'd0, 16'd0, 16'd0);
      send_request(32'hdeadbeef, 0);
      send_request(32'hffffffff, 0);
      set_shape(16'd3, 16'd0, 16'd5, 16'd7);
      for (int i = 100; i < 110; i++) send_request(32'(i), 0);
      send_request(32'hffffffff, 0);
      set_shape(16'd2, 16'd2, 16'd2, 16'd2);
      send_request(32'd15, 0);
      send_request(32'd16, 0);
      send_request(32'h80000001, 0);
      // random phases, every third with a long receiver hold after its tenth request
      for (int p = 0; p < 12; p++) begin
         set_shape(rand_extent(), rand_extent(), rand_extent(), rand_extent());
         for (int i = 0; i < 50; i++) begin
            if (i == 10 && p % 3 == 0) hold_rsp = 1;
            send_request(rand_index(), $urandom_range(0, 3) != 0);
         end
      end
      drain();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
